/* hw/rtl/dfrp_pkg.sv */
// ---------------------------------------------------------------------------
// dfrp_pkg
// Shared constants for the PL2+ term score pipeline: data widths and the
// configuration register map.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dfrp_pkg;

  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 3;
  // integer part of a log2 result, signed
  localparam int LOG_INT_W = 7;

  // configuration register map
  localparam logic [CFG_IDX_W-1:0] REG_SCALED_AVG_LEN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POISSON_ONE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POISSON_TWO    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DELTA_CORR     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_FACTOR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_TERM    = 3'd5;

endpackage

`default_nettype wire

/* hw/rtl/dfrp_div.sv */
// ---------------------------------------------------------------------------
// dfrp_div
// Pipelined restoring divider, one quotient bit per stage, NUM_W stages.
// Sideband bits travel alongside each transaction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dfrp_div #(
  parameter int NUM_W  = 32,
  parameter int DEN_W  = 32,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [NUM_W-1:0]  in_num,
  input  wire logic [DEN_W-1:0]  in_den,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output logic [NUM_W-1:0]       out_quo,
  output logic [SIDE_W-1:0]      out_side
);

  logic              vld_r  [0:NUM_W-1];
  logic [DEN_W-1:0]  rem_r  [0:NUM_W-1];
  logic [NUM_W-1:0]  nq_r   [0:NUM_W-1];
  logic [DEN_W-1:0]  den_r  [0:NUM_W-1];
  logic [SIDE_W-1:0] side_r [0:NUM_W-1];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic              vld_in;
    logic [DEN_W-1:0]  rem_in;
    logic [NUM_W-1:0]  nq_in;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;
    logic [DEN_W-1:0]  rem_nxt;
    logic [NUM_W-1:0]  nq_nxt;

    if (k == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = '0;
      assign nq_in   = in_num;
      assign den_in  = in_den;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign nq_in   = nq_r[k-1];
      assign den_in  = den_r[k-1];
      assign side_in = side_r[k-1];
    end

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
      trial   = {rem_in, nq_in[NUM_W-1]};
      diff    = trial - {1'b0, den_in};
      ge      = (trial >= {1'b0, den_in});
      rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      nq_nxt  = {nq_in[NUM_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        nq_r[k]   <= nq_nxt;
        den_r[k]  <= den_in;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[NUM_W-1];
  assign out_quo   = nq_r[NUM_W-1];
  assign out_side  = side_r[NUM_W-1];

endmodule

`default_nettype wire

/* hw/rtl/dfrp_log2.sv */
// ---------------------------------------------------------------------------
// dfrp_log2
// Pipelined fixed-point log2: one normalize stage, then one squaring
// stage per fraction bit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dfrp_log2 #(
  parameter int FRAC_BITS = 16,
  parameter int IN_W      = 32,
  parameter int SIDE_W    = 1
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    en,
  input  wire logic                                    in_valid,
  input  wire logic [IN_W-1:0]                         in_val,
  input  wire logic [SIDE_W-1:0]                       in_side,
  output logic                                         out_valid,
  output logic signed [dfrp_pkg::LOG_INT_W+FRAC_BITS-1:0] out_lg,
  output logic [SIDE_W-1:0]                            out_side
);
  import dfrp_pkg::*;

  localparam int POS_W = $clog2(IN_W);

  logic                 vld_r  [0:FRAC_BITS];
  logic [30:0]          m_r    [0:FRAC_BITS];
  logic [LOG_INT_W-1:0] int_r  [0:FRAC_BITS];
  logic [FRAC_BITS-1:0] frac_r [0:FRAC_BITS];
  logic [SIDE_W-1:0]    side_r [0:FRAC_BITS];

  // leading-one position and normalization to bit 30
  logic [POS_W-1:0] pos;
  logic [63:0]      ext;
  logic [63:0]      shifted;

  always_comb begin
    pos = '0;
    for (int i = 0; i < IN_W; i++) begin
      if (in_val[i]) pos = POS_W'(i);
    end
    ext = 64'(in_val);
    if (pos > POS_W'(30)) shifted = ext >> (pos - POS_W'(30));
    else                  shifted = ext << (POS_W'(30) - pos);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0]    <= shifted[30:0];
      int_r[0]  <= LOG_INT_W'(pos) - LOG_INT_W'(FRAC_BITS);
      frac_r[0] <= '0;
      side_r[0] <= in_side;
    end
  end

  // squaring stages, one fraction bit each
  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_sq
    logic [61:0] prod;
    logic [31:0] sq;

    always_comb begin
      prod = 62'(m_r[k-1]) * 62'(m_r[k-1]);
      sq   = prod[61:30];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_r[k]    <= sq[31] ? sq[31:1] : sq[30:0];
        int_r[k]  <= int_r[k-1];
        frac_r[k] <= {frac_r[k-1][FRAC_BITS-2:0], sq[31]};
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_valid = vld_r[FRAC_BITS];
  assign out_lg    = $signed({int_r[FRAC_BITS], frac_r[FRAC_BITS]});
  assign out_side  = side_r[FRAC_BITS];

endmodule

`default_nettype wire

/* hw/rtl/dfr_pl2plus_term_score.sv */
// ---------------------------------------------------------------------------
// dfr_pl2plus_term_score
// PL2+ divergence-from-randomness term weight for one posting, fixed point,
// fully pipelined.
// ---------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  in_       slave      in_tvalid/tready    tdata: term_freq, doc_len
//  out_      master     out_tvalid/tready   tdata: score; tuser: saturated
//  cfg_      write      cfg_wr_en           cfg_idx, cfg_wdata
//
//  One transaction per cycle while the output is not stalled; the path runs
//  through the two bit-per-stage dividers and the two log2 squaring chains.
//  Synchronous active-low reset clears the valid bits and the config registers (ignore-term is set).
//  The whole pipeline advances when the output register is empty or taken;
//  otherwise every stage holds.
`timescale 1ns / 1ps
`default_nettype none

module dfr_pl2plus_term_score #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // config
  input  wire logic                             cfg_wr_en,
  input  wire logic [dfrp_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [dfrp_pkg::DATA_W-1:0]      cfg_wdata,
  // input stream
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [63:0]                      in_tdata,  // term_freq, doc_len
  // result stream
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [31:0]                           out_tdata, // score
  output logic [0:0]                            out_tuser  // saturated
);
  import dfrp_pkg::*;

  localparam int LG_W  = LOG_INT_W + FRAC_BITS;
  localparam int P1_W  = 32 + LG_W - 1;
  localparam int T1_W  = 34 + LG_W;
  localparam int DIV_W = 64 + FRAC_BITS;
  localparam logic [32:0] ONE_C  = 33'd1 << FRAC_BITS;
  localparam logic [32:0] HALF_C = 33'd1 << (FRAC_BITS - 1);

  // configuration registers
  logic [31:0]        sal_r;
  logic signed [31:0] p1_r;
  logic signed [31:0] p2_r;
  logic signed [31:0] delta_r;
  logic [31:0]        qf_r;
  logic               ignore_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sal_r    <= '0;
      p1_r     <= '0;
      p2_r     <= '0;
      delta_r  <= '0;
      qf_r     <= '0;
      ignore_r <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_idx)
        REG_SCALED_AVG_LEN: sal_r    <= cfg_wdata;
        REG_POISSON_ONE:    p1_r     <= $signed(cfg_wdata);
        REG_POISSON_TWO:    p2_r     <= $signed(cfg_wdata);
        REG_DELTA_CORR:     delta_r  <= $signed(cfg_wdata);
        REG_QUERY_FACTOR:   qf_r     <= cfg_wdata;
        REG_IGNORE_TERM:    ignore_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // global advance
  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // input: zero-score flag, length clamp
  logic [31:0] tf_in, len_in;
  logic        zero_in;
  assign tf_in   = in_tdata[31:0];
  assign len_in  = (in_tdata[63:32] == '0) ? 32'd1 : in_tdata[63:32];
  assign zero_in = (tf_in == '0) || ignore_r;

  // scaled length / doc length
  logic        d1_vld;
  logic [31:0] d1_quo;
  logic [32:0] d1_side;

  dfrp_div #(.NUM_W(32), .DEN_W(32), .SIDE_W(33)) u_div_len (
    .clk, .rst_n, .en(adv),
    .in_valid(in_tvalid && in_tready), .in_num(sal_r), .in_den(len_in),
    .in_side({zero_in, tf_in}),
    .out_valid(d1_vld), .out_quo(d1_quo), .out_side(d1_side)
  );

  // log2(1 + ratio)
  logic                   l1_vld;
  logic signed [LG_W-1:0] l1_lg;
  logic [32:0]            l1_side;

  dfrp_log2 #(.FRAC_BITS(FRAC_BITS), .IN_W(33), .SIDE_W(33)) u_log_norm (
    .clk, .rst_n, .en(adv),
    .in_valid(d1_vld), .in_val({1'b0, d1_quo} + ONE_C), .in_side(d1_side),
    .out_valid(l1_vld), .out_lg(l1_lg), .out_side(l1_side)
  );

  // stage M1: tf * log term
  logic            m1_vld_r;
  logic [P1_W-1:0] m1_prod_r;
  logic            m1_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) m1_vld_r <= 1'b0;
    else if (adv) m1_vld_r <= l1_vld;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m1_prod_r <= P1_W'(l1_side[31:0]) * P1_W'(l1_lg[LG_W-2:0]);
      m1_zero_r <= l1_side[32];
    end
  end

  // stage M2: saturate normalized frequency
  logic        m2_vld_r;
  logic [31:0] wdfn_m2_r;
  logic        m2_zero_r;
  logic [31:0] wdfn_nxt;

  assign wdfn_nxt = (|m1_prod_r[P1_W-1:32]) ? 32'hFFFF_FFFF : m1_prod_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) m2_vld_r <= 1'b0;
    else if (adv) m2_vld_r <= m1_vld_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      wdfn_m2_r <= wdfn_nxt;
      m2_zero_r <= m1_zero_r || (wdfn_nxt == '0);
    end
  end

  // log2(wdfn)
  logic                   l2_vld;
  logic signed [LG_W-1:0] l2_lg;
  logic [32:0]            l2_side;

  dfrp_log2 #(.FRAC_BITS(FRAC_BITS), .IN_W(32), .SIDE_W(33)) u_log_freq (
    .clk, .rst_n, .en(adv),
    .in_valid(m2_vld_r), .in_val(wdfn_m2_r), .in_side({m2_zero_r, wdfn_m2_r}),
    .out_valid(l2_vld), .out_lg(l2_lg), .out_side(l2_side)
  );

  // stage T: the two Poisson products
  logic                   t_vld_r;
  logic signed [T1_W-1:0] t_term1_r;
  logic signed [64:0]     t_term2_r;
  logic [31:0]            wdfn_t_r;
  logic                   t_zero_r;
  logic [32:0]            wdfn_half;

  assign wdfn_half = {1'b0, l2_side[31:0]} + HALF_C;

  always_ff @(posedge clk) begin
    if (!rst_n) t_vld_r <= 1'b0;
    else if (adv) t_vld_r <= l2_vld;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      t_term1_r <= T1_W'($signed({1'b0, wdfn_half})) * T1_W'(l2_lg);
      t_term2_r <= 65'(p2_r) * $signed({1'b0, l2_side[31:0]});
      wdfn_t_r  <= l2_side[31:0];
      t_zero_r  <= l2_side[32];
    end
  end

  // stage P: P = P1 + floor(term1) - floor(term2)
  logic               p_vld_r;
  logic signed [63:0] p_r;
  logic [31:0]        wdfn_p_r;
  logic               p_zero_r;
  logic signed [71:0] p_sum;

  assign p_sum = 72'(p1_r) + (72'(t_term1_r) >>> FRAC_BITS)
               - (72'(t_term2_r) >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) p_vld_r <= 1'b0;
    else if (adv) p_vld_r <= t_vld_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      p_r      <= p_sum[63:0];
      wdfn_p_r <= wdfn_t_r;
      p_zero_r <= t_zero_r;
    end
  end

  // stage S: sign and magnitude, divisor
  logic        s_vld_r;
  logic [63:0] s_mag_r;
  logic [32:0] s_den_r;
  logic        s_neg_r;
  logic        s_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s_vld_r <= 1'b0;
    else if (adv) s_vld_r <= p_vld_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s_neg_r  <= p_r[63];
      s_mag_r  <= p_r[63] ? 64'(-p_r) : 64'(p_r);
      s_den_r  <= {1'b0, wdfn_p_r} + ONE_C;
      s_zero_r <= p_zero_r;
    end
  end

  // P * 2^F / (wdfn + 1)
  logic             d2_vld;
  logic [DIV_W-1:0] d2_quo;
  logic [1:0]       d2_side;

  dfrp_div #(.NUM_W(DIV_W), .DEN_W(33), .SIDE_W(2)) u_div_wt (
    .clk, .rst_n, .en(adv),
    .in_valid(s_vld_r), .in_num({s_mag_r, {FRAC_BITS{1'b0}}}), .in_den(s_den_r),
    .in_side({s_zero_r, s_neg_r}),
    .out_valid(d2_vld), .out_quo(d2_quo), .out_side(d2_side)
  );

  // stage W: signed weight plus correction
  logic               w_vld_r;
  logic [63:0]        w_wt_r;
  logic               w_zero_r;
  logic signed [64:0] q_s;
  logic signed [65:0] wt_s;

  assign q_s  = d2_side[0] ? -$signed({1'b0, d2_quo[63:0]}) : $signed({1'b0, d2_quo[63:0]});
  assign wt_s = 66'(q_s) + 66'(delta_r);

  always_ff @(posedge clk) begin
    if (!rst_n) w_vld_r <= 1'b0;
    else if (adv) w_vld_r <= d2_vld;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      w_wt_r   <= wt_s[63:0];
      w_zero_r <= d2_side[1] || (wt_s <= 66'sd0);
    end
  end

  // stage X: factor times high and low halves
  logic        x_vld_r;
  logic [63:0] x_hi_r;
  logic [63:0] x_lo_r;
  logic        x_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) x_vld_r <= 1'b0;
    else if (adv) x_vld_r <= w_vld_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      x_hi_r   <= 64'(qf_r) * 64'(w_wt_r[63:32]);
      x_lo_r   <= 64'(qf_r) * 64'(w_wt_r[31:0]);
      x_zero_r <= w_zero_r;
    end
  end

  // output register: combine, saturate
  logic [64:0] sum;
  logic        sat;
  logic [31:0] score_r;
  logic        sat_r;
  logic        out_vld_r;

  always_comb begin
    sum = 65'({x_hi_r[FRAC_BITS-1:0], {(32-FRAC_BITS){1'b0}}}) + 65'(x_lo_r >> FRAC_BITS);
    sat = (|x_hi_r[63:FRAC_BITS]) || (|sum[64:32]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (adv) out_vld_r <= x_vld_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      score_r <= x_zero_r ? 32'd0 : (sat ? 32'hFFFF_FFFF : sum[31:0]);
      sat_r   <= !x_zero_r && sat;
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = score_r;
  assign out_tuser[0] = sat_r;

endmodule

`default_nettype wire

/* hw/rtl/dfrp_checker.sv */
// ---------------------------------------------------------------------------
// dfrp_checker
// Port-level checks for the term score pipeline, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dfrp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [0:0]  out_tuser
);
  import dfrp_pkg::*;

  // a saturated result always carries the full-scale score
  a_sat_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == {DATA_W{1'b1}})
    else $error("saturated result without full-scale score");

  // input side only stalls when a result is held back
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  // held result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind dfr_pl2plus_term_score dfrp_checker u_dfrp_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser)
);

`default_nettype wire
